[rtl/core/fct_pkg.sv]
// Shared types and constants for the frustum cull test block.
package fct_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned NormW  = 16;
  localparam int unsigned OffW   = 31;

  typedef enum logic [1:0] {
    KIND_SPHERE = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_LOAD   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               plane_set;
    logic [2:0]         plane_index;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] margin;
  } in_word_t;

  typedef struct packed {
    logic       visible;
    logic [2:0] culling_plane;
  } out_word_t;

  // Classified test handed from front to back: widened bounds are 33 bits.
  typedef struct packed {
    kind_t              kind;
    logic [1:0]         set_sel;
    logic signed [32:0] lo_x;
    logic signed [32:0] lo_y;
    logic signed [32:0] lo_z;
    logic signed [32:0] hi_x;
    logic signed [32:0] hi_y;
    logic signed [32:0] hi_z;
    logic signed [31:0] margin;
  } task_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } back_state_t;

endpackage

[rtl/core/fct_front.sv]
// Front end: accepts words, writes plane loads, classifies and widens tests.
module fct_front #(
  parameter int unsigned PLANES_PER_SET = 6,
  parameter int unsigned PLANE_SETS     = 2,
  parameter int unsigned SET_W          = 2,
  parameter int unsigned PIDX_W         = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  fct_pkg::in_word_t        in_word,
  input  logic [30:0]              box_offset,
  output logic                     q_valid,
  input  logic                     q_stall,
  output fct_pkg::task_t           q_word,
  output logic                     wr_en,
  output logic [PIDX_W-1:0]        wr_idx,
  output logic [3*16+32-1:0]       wr_data
);
  import fct_pkg::*;

  logic                 acc;
  logic [SET_W-1:0]     set_sel;
  logic signed [32:0]   off;
  task_t                q_next;

  // a load waits until no earlier test is queued or in the back end
  assign in_stall = (q_valid && q_stall) ||
                    ((in_word.kind == KIND_LOAD) && (q_valid || q_stall));
  assign acc      = in_valid && !in_stall;
  assign off      = {2'b00, box_offset};

  // saturate the set select to the last set
  always_comb begin
    if (32'(in_word.plane_set) >= PLANE_SETS) set_sel = SET_W'(PLANE_SETS - 1);
    else set_sel = SET_W'(in_word.plane_set);
  end

  // plane load write port
  assign wr_en   = acc && (in_word.kind == KIND_LOAD) &&
                   (32'(in_word.plane_index) < PLANES_PER_SET);
  assign wr_idx  = PIDX_W'(32'(set_sel) * PLANES_PER_SET + 32'(in_word.plane_index));
  assign wr_data = {in_word.ax[15:0], in_word.ay[15:0], in_word.az[15:0], in_word.margin};

  // classify and widen
  always_comb begin
    q_next.kind    = kind_t'(in_word.kind);
    q_next.set_sel = (in_word.kind == KIND_BOX) ? 2'd0 : 2'(set_sel);
    q_next.margin  = in_word.margin;
    q_next.lo_x    = 33'(in_word.ax);
    q_next.lo_y    = 33'(in_word.ay);
    q_next.lo_z    = 33'(in_word.az);
    q_next.hi_x    = 33'(in_word.bx);
    q_next.hi_y    = 33'(in_word.by);
    q_next.hi_z    = 33'(in_word.bz);
    if (in_word.kind == KIND_BOX) begin
      q_next.lo_x = 33'(in_word.ax) - off;
      q_next.lo_y = 33'(in_word.ay) - off;
      q_next.lo_z = 33'(in_word.az) - off;
      q_next.hi_x = 33'(in_word.bx) + off;
      q_next.hi_y = 33'(in_word.by) + off;
      q_next.hi_z = 33'(in_word.bz) + off;
    end
  end

  // single-entry queue register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (acc) begin
      q_valid <= 1'b1;
    end else if (!q_stall) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_word <= q_next;
    end
  end
endmodule

[rtl/core/fct_back.sv]
// Back end: sequential plane sweep with one shared three-term dot product unit.
module fct_back #(
  parameter int unsigned PLANES_PER_SET = 6,
  parameter int unsigned PLANE_SETS     = 2,
  parameter int unsigned PIDX_W         = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_stall,
  input  fct_pkg::task_t     q_word,
  input  logic               wr_en,
  input  logic [PIDX_W-1:0]  wr_idx,
  input  logic [79:0]        wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fct_pkg::out_word_t out_word
);
  import fct_pkg::*;

  localparam int unsigned TOTAL = PLANES_PER_SET * PLANE_SETS;
  localparam int unsigned CNT_W = $clog2(PLANES_PER_SET + 1);

  logic [79:0]           planes [TOTAL];
  back_state_t           state, state_next;
  task_t                 cur;
  logic [CNT_W-1:0]      cnt;
  logic [79:0]           pl;
  logic signed [15:0]    nx, ny, nz;
  logic signed [31:0]    pd;
  logic signed [49:0]    px, py, pz;
  logic signed [49:0]    tx, ty, tz;
  logic signed [52:0]    dot, lim;
  logic                  hit;
  logic                  take;

  // plane storage, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOTAL; i++) planes[i] <= '0;
    end else if (wr_en) begin
      planes[wr_idx] <= wr_data;
    end
  end

  assign pl = planes[PIDX_W'(32'(cur.set_sel) * PLANES_PER_SET + 32'(cnt))];
  assign nx = pl[79:64];
  assign ny = pl[63:48];
  assign nz = pl[47:32];

  // products; box picks the smaller of the two corner products
  function automatic logic signed [49:0] pick(input logic signed [15:0] n,
      input logic signed [32:0] lo, input logic signed [32:0] hi, input logic is_box);
    logic signed [49:0] p0, p1;
    begin
      p0 = 50'(n * lo);
      p1 = 50'(n * hi);
      pick = (is_box && p1 < p0) ? p1 : p0;
    end
  endfunction

  // multiply stage registers
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      px <= pick(nx, cur.lo_x, cur.hi_x, cur.kind == KIND_BOX);
      py <= pick(ny, cur.lo_y, cur.hi_y, cur.kind == KIND_BOX);
      pz <= pick(nz, cur.lo_z, cur.hi_z, cur.kind == KIND_BOX);
      pd <= pl[31:0];
    end
  end
  assign tx = px;
  assign ty = py;
  assign tz = pz;

  assign dot = 53'(tx) + 53'(ty) + 53'(tz) + (53'(pd) <<< 14);
  assign lim = 53'(cur.margin) <<< 14;
  assign hit = (cur.kind == KIND_BOX) ? (dot > 0) : (lim < dot);

  assign take    = (state == ST_IDLE) && q_valid;
  assign q_stall = !(state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) begin
        state_next = (q_word.kind == KIND_SPHERE || q_word.kind == KIND_BOX) ?
                     ST_MUL : ST_OUT;
      end
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = (hit || 32'(cnt) == PLANES_PER_SET - 1) ? ST_OUT : ST_MUL;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur      <= q_word;
      cnt      <= '0;
      out_word <= '{visible: 1'b1, culling_plane: 3'd6};
    end else if (state == ST_SUM) begin
      if (hit) begin
        out_word <= '{visible: 1'b0, culling_plane: 3'(cnt)};
      end
      cnt <= cnt + 1'b1;
    end
  end
endmodule

[rtl/core/frustum_cull_test_top.sv]
// Top level of the frustum cull test block.
// All words pass the queue and output state; tests add a multiply and sum state per plane.
// Flow: the back end's shared dot product unit holds one word until its result is taken;
// the front queue takes the next test while a result waits, and a plane load waits for an
// empty queue and an idle back end so that it lands in word order.
// Reset (rst, synchronous): all planes and box_offset clear to zero, queue empties.
module frustum_cull_test_top #(
  parameter int unsigned PLANES_PER_SET = 6,
  parameter int unsigned PLANE_SETS     = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  fct_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output fct_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_data
);
  import fct_pkg::*;

  localparam int unsigned SET_W  = 2;
  localparam int unsigned PIDX_W = $clog2(PLANES_PER_SET * PLANE_SETS + 1);

  logic [30:0]        box_offset;
  logic               q_valid, q_stall, wr_en;
  task_t              q_word;
  logic [PIDX_W-1:0]  wr_idx;
  logic [79:0]        wr_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      box_offset <= '0;
    end else if (cfg_we) begin
      box_offset <= cfg_data;
    end
  end

  fct_front #(.PLANES_PER_SET(PLANES_PER_SET), .PLANE_SETS(PLANE_SETS),
              .SET_W(SET_W), .PIDX_W(PIDX_W)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_word, .box_offset,
    .q_valid, .q_stall, .q_word, .wr_en, .wr_idx, .wr_data
  );

  fct_back #(.PLANES_PER_SET(PLANES_PER_SET), .PLANE_SETS(PLANE_SETS),
             .PIDX_W(PIDX_W)) u_back (
    .clk, .rst, .q_valid, .q_stall, .q_word, .wr_en, .wr_idx, .wr_data,
    .out_valid, .out_stall, .out_word
  );
endmodule
